@@ rtl/rrts_pkg.sv @@
// Shared constants, codes and types of the round-robin thread scheduler.
package rrts_pkg;

    localparam int MAX_THREADS_DEF = 16;

    localparam int SLOT_W = 4;
    localparam int MODE_W = 3;
    localparam int DUR_W  = 32;
    localparam int RATE_W = 17;
    localparam int TICK_W = 64;
    localparam int PROD_W = RATE_W + DUR_W;
    localparam int MS_PER_S = 1000;

    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = RATE_W;

    // Event codes
    localparam logic [MODE_W-1:0] MODE_SCHED    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ADD      = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SLEEP_MS = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SLEEP_S  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_KILL     = 3'd4;
    localparam logic [MODE_W-1:0] MODE_EXIT     = 3'd5;
    localparam logic [MODE_W-1:0] MODE_TICK     = 3'd6;

    // Slot status codes
    localparam logic [1:0] ST_FREE    = 2'd0;
    localparam logic [1:0] ST_READY   = 2'd1;
    localparam logic [1:0] ST_RUNNING = 2'd2;
    localparam logic [1:0] ST_BLOCKED = 2'd3;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_TICK_RATE   = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_KERNEL_SLOT = 1'b1;

    localparam logic [RATE_W-1:0] TICK_RATE_RST   = 17'd1000;
    localparam logic [SLOT_W-1:0] KERNEL_SLOT_RST = 4'd0;

    typedef struct packed {
        logic start;
        logic ms;
    } conv_req_t;

    typedef struct packed {
        logic              rejected;
        logic              reclaimed;
        logic              fell_back;
        logic              switched;
        logic [SLOT_W-1:0] previous_slot;
        logic [SLOT_W-1:0] running_slot;
    } result_t;

endpackage

@@ rtl/rrts_conv.sv @@
// Sleep duration to tick conversion: one multiply, then for ms a divide by 1000 via reciprocal.
module rrts_conv (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  rrts_pkg::conv_req_t           req,
    input  logic [rrts_pkg::DUR_W-1:0]    dur,
    input  logic [rrts_pkg::RATE_W-1:0]   rate,
    output logic                          done,
    output logic [rrts_pkg::TICK_W-1:0]   delta
);

    localparam int PW = rrts_pkg::PROD_W;
    // x / 1000 = (x >> 3) / 125; (x >> 3) has 46 bits
    localparam int YW = PW - 3;
    localparam int MW = 47;
    localparam int AW = YW + MW;
    localparam int QS = 53;
    // ceil(2^53 / 125), exact for dividends below 2^50
    localparam logic [MW-1:0] RECIP = 47'd72057594037928;

    typedef enum logic [3:0] {
        CV_IDLE = 4'b0001,
        CV_DONE = 4'b0010,
        CV_DIV  = 4'b0100,
        CV_LOAD = 4'b1000
    } cv_state_t;

    cv_state_t       state_reg, state_next;
    logic [PW-1:0]   q_reg, q_next;
    logic [AW-1:0]   acc_reg, acc_next;
    logic [1:0]      cnt_reg, cnt_next;
    logic [YW-1:0]   y;
    logic [22:0]     op_a;
    logic [23:0]     op_b;
    logic [46:0]     pp;
    logic [AW-1:0]   pp_sh;

    assign y = q_reg[PW-1:3];

    // one 23 x 24 partial product per cycle, shifted into place
    always_comb begin
        unique case (cnt_reg)
            2'd0: begin
                op_a = y[22:0];
                op_b = RECIP[23:0];
            end
            2'd1: begin
                op_a = y[45:23];
                op_b = RECIP[23:0];
            end
            2'd2: begin
                op_a = y[22:0];
                op_b = {1'b0, RECIP[46:24]};
            end
            2'd3: begin
                op_a = y[45:23];
                op_b = {1'b0, RECIP[46:24]};
            end
        endcase
        pp = 47'(op_a) * 47'(op_b);
        unique case (cnt_reg)
            2'd0: pp_sh = AW'(pp);
            2'd1: pp_sh = AW'(pp) << 23;
            2'd2: pp_sh = AW'(pp) << 24;
            2'd3: pp_sh = AW'(pp) << 47;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        q_next     = q_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        done       = 1'b0;
        unique case (state_reg)
            CV_IDLE: begin
                if (req.start) begin
                    q_next     = PW'(dur) * PW'(rate);
                    acc_next   = '0;
                    cnt_next   = '0;
                    state_next = req.ms ? CV_DIV : CV_DONE;
                end
            end
            CV_DIV: begin
                acc_next = acc_reg + pp_sh;
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3) begin
                    state_next = CV_LOAD;
                end
            end
            CV_LOAD: begin
                q_next     = PW'(acc_reg[AW-1:QS]);
                state_next = CV_DONE;
            end
            CV_DONE: begin
                done       = 1'b1;
                state_next = CV_IDLE;
            end
            default: state_next = CV_IDLE;
        endcase
    end

    assign delta = rrts_pkg::TICK_W'(q_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CV_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg   <= q_next;
        acc_reg <= acc_next;
        cnt_reg <= cnt_next;
    end

endmodule

@@ rtl/rrts_ctrl.sv @@
// Event sequencer: status, ready, sleep and wake memories with read-modify-write passes.
module rrts_ctrl #(
    parameter int MAX_THREADS = rrts_pkg::MAX_THREADS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [rrts_pkg::MODE_W-1:0]   mode,
    input  logic [rrts_pkg::SLOT_W-1:0]   slot,
    input  logic [rrts_pkg::DUR_W-1:0]    dur,
    input  logic [rrts_pkg::RATE_W-1:0]   tick_rate,
    input  logic [rrts_pkg::SLOT_W-1:0]   kernel_slot,
    output logic                          idle,
    output logic                          res_valid,
    output rrts_pkg::result_t             res,
    input  logic                          res_ready
);

    localparam int IDX_W = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
    localparam int CNT_W = $clog2(MAX_THREADS + 1);
    localparam int TW    = rrts_pkg::TICK_W;

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_ADD   = 13'b0000000000010,
        S_KILL  = 13'b0000000000100,
        S_CONV  = 13'b0000000001000,
        S_RMS   = 13'b0000000010000,
        S_RMR   = 13'b0000000100000,
        S_PUSHS = 13'b0000001000000,
        S_SCH0  = 13'b0000010000000,
        S_SCH1  = 13'b0000100000000,
        S_WAKE  = 13'b0001000000000,
        S_PICK  = 13'b0010000000000,
        S_FIN   = 13'b0100000000000,
        S_DONE  = 13'b1000000000000
    } state_t;

    // what follows the removal passes
    localparam logic [1:0] OP_END   = 2'd0;
    localparam logic [1:0] OP_KILL  = 2'd1;
    localparam logic [1:0] OP_SLEEP = 2'd2;

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    run_reg, run_next;
    logic [IDX_W-1:0]    prev_reg, prev_next;
    logic [IDX_W-1:0]    next_reg, next_next;
    logic [IDX_W-1:0]    tgt_reg, tgt_next;
    logic [IDX_W-1:0]    s2_reg, s2_next;
    logic [CNT_W-1:0]    rcnt_reg, rcnt_next;
    logic [CNT_W-1:0]    scnt_reg, scnt_next;
    logic [CNT_W-1:0]    rd_reg, rd_next;
    logic [CNT_W-1:0]    wr_reg, wr_next;
    logic [TW-1:0]       tick_reg, tick_next;
    logic                pv_reg, pv_next;
    logic                pv2_reg, pv2_next;
    logic                found_reg, found_next;
    logic                dying_reg, dying_next;
    logic                fallback_reg, fallback_next;
    logic [1:0]          op_reg, op_next;
    logic [1:0]          stval_reg, stval_next;
    rrts_pkg::result_t   res_reg, res_next;

    // memories and their ports
    logic [IDX_W-1:0]    ready_mem [MAX_THREADS];
    logic [IDX_W-1:0]    sleep_mem [MAX_THREADS];
    logic [TW-1:0]       wake_mem  [MAX_THREADS];
    logic [1:0]          stat_mem  [MAX_THREADS];
    logic [MAX_THREADS-1:0] vld_reg;

    logic                rwe, swe, wwe, stwe;
    logic [IDX_W-1:0]    rwa, swa, wwa, stwa, rra, sra, wra, stra;
    logic [IDX_W-1:0]    rwd, swd;
    logic [TW-1:0]       wwd;
    logic [1:0]          stwd;
    logic [IDX_W-1:0]    rrd_reg, srd_reg;
    logic [TW-1:0]       wrd_reg;
    logic [1:0]          strd_reg;
    logic                stv_reg, st0_reg;
    logic [1:0]          stat_rd;

    // list filter engine
    logic                f_active, f_sleep, f_head, f_issue, f_drop, f_keep, f_done;
    logic [CNT_W-1:0]    f_cnt;
    logic [IDX_W-1:0]    f_data;
    logic                w_issue, w_done, slot_ok, kern_ok, ready_room, sleep_room;
    logic [IDX_W-1:0]    kern;

    rrts_pkg::conv_req_t conv_req;
    logic                conv_done;
    logic [TW-1:0]       conv_delta;

    rrts_conv u_conv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (conv_req),
        .dur     (dur),
        .rate    (tick_rate),
        .done    (conv_done),
        .delta   (conv_delta)
    );

    // status entries never written read as their reset value
    assign stat_rd = stv_reg ? strd_reg : (st0_reg ? rrts_pkg::ST_RUNNING : rrts_pkg::ST_FREE);

    assign slot_ok    = 32'(slot) < 32'(MAX_THREADS);
    assign kern_ok    = 32'(kernel_slot) < 32'(MAX_THREADS);
    assign kern       = kern_ok ? IDX_W'(kernel_slot) : '0;
    assign ready_room = rcnt_reg < CNT_W'(MAX_THREADS);
    assign sleep_room = scnt_reg < CNT_W'(MAX_THREADS);

    assign f_active = (state_reg == S_RMS) || (state_reg == S_RMR) || (state_reg == S_PICK);
    assign f_sleep  = (state_reg == S_RMS) || ((state_reg == S_PICK) && fallback_reg);
    assign f_head   = (state_reg == S_PICK) && !fallback_reg;
    assign f_cnt    = f_sleep ? scnt_reg : rcnt_reg;
    assign f_data   = f_sleep ? srd_reg : rrd_reg;
    assign f_issue  = rd_reg < f_cnt;
    assign f_drop   = pv_reg && !found_reg && (f_head || (f_data == tgt_reg));
    assign f_keep   = pv_reg && !f_drop;
    assign f_done   = !f_issue && !pv_reg;

    assign w_issue  = rd_reg < scnt_reg;
    assign w_done   = !w_issue && !pv_reg && !pv2_reg;

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    always_comb begin
        state_next    = state_reg;
        run_next      = run_reg;
        prev_next     = prev_reg;
        next_next     = next_reg;
        tgt_next      = tgt_reg;
        s2_next       = s2_reg;
        rcnt_next     = rcnt_reg;
        scnt_next     = scnt_reg;
        rd_next       = rd_reg;
        wr_next       = wr_reg;
        tick_next     = tick_reg;
        pv_next       = pv_reg;
        pv2_next      = pv2_reg;
        found_next    = found_reg;
        dying_next    = dying_reg;
        fallback_next = fallback_reg;
        op_next       = op_reg;
        stval_next    = stval_reg;
        res_next      = res_reg;
        conv_req      = '0;
        rwe  = 1'b0; swe = 1'b0; wwe = 1'b0; stwe = 1'b0;
        rwa  = wr_reg[IDX_W-1:0];
        swa  = wr_reg[IDX_W-1:0];
        wwa  = run_reg;
        stwa = tgt_reg;
        rwd  = f_data;
        swd  = f_data;
        wwd  = tick_reg + conv_delta;
        stwd = stval_reg;
        rra  = rd_reg[IDX_W-1:0];
        sra  = rd_reg[IDX_W-1:0];
        wra  = srd_reg;
        stra = run_reg;

        // one entry per cycle: drop the match (or the head), pack the rest down
        if (f_active) begin
            if (f_issue) begin
                rd_next = rd_reg + CNT_W'(1);
            end
            pv_next = f_issue;
            if (f_drop) begin
                found_next = 1'b1;
            end
            if (f_keep) begin
                rwe     = !f_sleep;
                swe     = f_sleep;
                wr_next = wr_reg + CNT_W'(1);
            end
        end

        unique case (state_reg)
            S_IDLE: begin
                stra = IDX_W'(slot);
                if (start) begin
                    tgt_next   = IDX_W'(slot);
                    prev_next  = run_reg;
                    dying_next = 1'b0;
                    rd_next    = '0;
                    wr_next    = '0;
                    pv_next    = 1'b0;
                    pv2_next   = 1'b0;
                    found_next = 1'b0;
                    res_next   = '0;
                    res_next.running_slot  = rrts_pkg::SLOT_W'(run_reg);
                    res_next.previous_slot = rrts_pkg::SLOT_W'(run_reg);
                    if (mode == rrts_pkg::MODE_SCHED) begin
                        state_next = S_SCH0;
                    end else if (mode == rrts_pkg::MODE_ADD) begin
                        res_next.rejected = !slot_ok;
                        state_next = slot_ok ? S_ADD : S_DONE;
                    end else if (mode == rrts_pkg::MODE_SLEEP_MS ||
                                 mode == rrts_pkg::MODE_SLEEP_S) begin
                        if (dur != '0) begin
                            conv_req.start = 1'b1;
                            conv_req.ms    = (mode == rrts_pkg::MODE_SLEEP_MS);
                            state_next     = S_CONV;
                        end else begin
                            state_next = S_DONE;
                        end
                    end else if (mode == rrts_pkg::MODE_KILL) begin
                        res_next.rejected = !slot_ok;
                        state_next = slot_ok ? S_KILL : S_DONE;
                    end else if (mode == rrts_pkg::MODE_EXIT) begin
                        tgt_next   = run_reg;
                        dying_next = 1'b1;
                        stval_next = rrts_pkg::ST_FREE;
                        op_next    = OP_END;
                        state_next = S_RMS;
                    end else if (mode == rrts_pkg::MODE_TICK) begin
                        tick_next  = tick_reg + TW'(1);
                        state_next = S_DONE;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_ADD: begin
                if (stat_rd != rrts_pkg::ST_FREE) begin
                    res_next.rejected = 1'b1;
                end else begin
                    stwe = 1'b1;
                    stwd = rrts_pkg::ST_READY;
                    if (ready_room) begin
                        rwe       = 1'b1;
                        rwa       = rcnt_reg[IDX_W-1:0];
                        rwd       = tgt_reg;
                        rcnt_next = rcnt_reg + CNT_W'(1);
                    end
                end
                state_next = S_DONE;
            end
            S_KILL: begin
                stval_next = rrts_pkg::ST_FREE;
                if (stat_rd == rrts_pkg::ST_FREE) begin
                    res_next.rejected = 1'b1;
                    state_next = S_DONE;
                end else if (tgt_reg == run_reg) begin
                    dying_next = 1'b1;
                    op_next    = OP_END;
                    state_next = S_RMS;
                end else begin
                    op_next    = OP_KILL;
                    state_next = S_RMS;
                end
            end
            S_CONV: begin
                if (conv_done) begin
                    wwe        = 1'b1;
                    tgt_next   = run_reg;
                    stval_next = rrts_pkg::ST_BLOCKED;
                    op_next    = OP_SLEEP;
                    state_next = S_RMS;
                end
            end
            S_RMS: begin
                if (f_done) begin
                    scnt_next  = wr_reg;
                    rd_next    = '0;
                    wr_next    = '0;
                    found_next = 1'b0;
                    state_next = S_RMR;
                end
            end
            S_RMR: begin
                if (f_done) begin
                    rcnt_next  = wr_reg;
                    rd_next    = '0;
                    wr_next    = '0;
                    found_next = 1'b0;
                    stwe       = 1'b1;
                    priority if (op_reg == OP_KILL) begin
                        state_next = S_DONE;
                    end else if (op_reg == OP_SLEEP) begin
                        state_next = S_PUSHS;
                    end else begin
                        state_next = S_SCH0;
                    end
                end
            end
            S_PUSHS: begin
                if (sleep_room) begin
                    swe       = 1'b1;
                    swa       = scnt_reg[IDX_W-1:0];
                    swd       = run_reg;
                    scnt_next = scnt_reg + CNT_W'(1);
                end
                state_next = S_SCH0;
            end
            S_SCH0: begin
                state_next = S_SCH1;
            end
            S_SCH1: begin
                // a still running thread goes to the back of the ready list
                if (stat_rd == rrts_pkg::ST_RUNNING) begin
                    stwe = 1'b1;
                    stwa = run_reg;
                    stwd = rrts_pkg::ST_READY;
                    if (ready_room) begin
                        rwe       = 1'b1;
                        rwa       = rcnt_reg[IDX_W-1:0];
                        rwd       = run_reg;
                        rcnt_next = rcnt_reg + CNT_W'(1);
                    end
                end
                rd_next    = '0;
                wr_next    = '0;
                pv_next    = 1'b0;
                pv2_next   = 1'b0;
                state_next = S_WAKE;
            end
            S_WAKE: begin
                // read sleep entry, then its wake tick, then move or keep it
                if (w_issue) begin
                    rd_next = rd_reg + CNT_W'(1);
                end
                pv_next  = w_issue;
                pv2_next = pv_reg;
                s2_next  = srd_reg;
                if (pv2_reg) begin
                    if (tick_reg >= wrd_reg) begin
                        stwe = 1'b1;
                        stwa = s2_reg;
                        stwd = rrts_pkg::ST_READY;
                        if (ready_room) begin
                            rwe       = 1'b1;
                            rwa       = rcnt_reg[IDX_W-1:0];
                            rwd       = s2_reg;
                            rcnt_next = rcnt_reg + CNT_W'(1);
                        end
                    end else begin
                        swe     = 1'b1;
                        swd     = s2_reg;
                        wr_next = wr_reg + CNT_W'(1);
                    end
                end
                if (w_done) begin
                    scnt_next     = wr_reg;
                    fallback_next = (rcnt_reg == '0);
                    tgt_next      = kern;
                    rd_next       = '0;
                    wr_next       = '0;
                    found_next    = 1'b0;
                    state_next    = S_PICK;
                end
            end
            S_PICK: begin
                if (f_head && f_drop) begin
                    next_next = f_data;
                end
                if (f_done) begin
                    if (fallback_reg) begin
                        scnt_next = wr_reg;
                        next_next = tgt_reg;
                    end else begin
                        rcnt_next = wr_reg;
                    end
                    res_next.fell_back = fallback_reg;
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                run_next = next_reg;
                stwe     = 1'b1;
                stwa     = next_reg;
                stwd     = rrts_pkg::ST_RUNNING;
                res_next.running_slot = rrts_pkg::SLOT_W'(next_reg);
                res_next.switched     = (prev_reg != next_reg);
                res_next.reclaimed    = dying_reg && (prev_reg != next_reg);
                state_next = S_DONE;
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            run_reg   <= '0;
            rcnt_reg  <= '0;
            scnt_reg  <= '0;
            tick_reg  <= '0;
            pv_reg    <= 1'b0;
            pv2_reg   <= 1'b0;
            vld_reg   <= '0;
        end else begin
            state_reg <= state_next;
            run_reg   <= run_next;
            rcnt_reg  <= rcnt_next;
            scnt_reg  <= scnt_next;
            tick_reg  <= tick_next;
            pv_reg    <= pv_next;
            pv2_reg   <= pv2_next;
            if (stwe) begin
                vld_reg[stwa] <= 1'b1;
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        prev_reg     <= prev_next;
        next_reg     <= next_next;
        tgt_reg      <= tgt_next;
        s2_reg       <= s2_next;
        rd_reg       <= rd_next;
        wr_reg       <= wr_next;
        found_reg    <= found_next;
        dying_reg    <= dying_next;
        fallback_reg <= fallback_next;
        op_reg       <= op_next;
        stval_reg    <= stval_next;
        res_reg      <= res_next;
    end

    // memories, one write and one registered read each
    always_ff @(posedge aclk) begin
        if (rwe) begin
            ready_mem[rwa] <= rwd;
        end
        rrd_reg <= ready_mem[rra];
        if (swe) begin
            sleep_mem[swa] <= swd;
        end
        srd_reg <= sleep_mem[sra];
        if (wwe) begin
            wake_mem[wwa] <= wwd;
        end
        wrd_reg <= wake_mem[wra];
        if (stwe) begin
            stat_mem[stwa] <= stwd;
        end
        strd_reg <= stat_mem[stra];
        stv_reg  <= vld_reg[stra];
        st0_reg  <= (stra == '0);
    end

endmodule

@@ rtl/round_robin_thread_scheduler_core.sv @@
// Top level of the round-robin thread scheduler: stream ports, config registers, result register.
//
// One request is one scheduler event and gives exactly one result. Requests are taken one at a
// time; the result sits in an output register so the next request can be taken while it waits.
// Tick, undefined events, zero-length sleeps and out-of-range slots go straight to the result;
// add, and kill of a free slot, first read the slot status. A list pass reads each entry once;
// kill of a waiting thread makes two passes (sleep list, then ready list). A schedule requeues a
// still running thread, makes the wake check over the sleep list (one entry per cycle through
// the sleep, wake and ready memories) and then the head removal pass over the ready list (with an
// empty ready list, removal of the kernel slot from the sleep list). Sleep, exit and kill of the
// running thread make the two removal passes first; a sleep also converts its duration to ticks
// before them (for milliseconds with a reciprocal multiply for the divide by 1000). Config writes
// are taken any time and must only be issued while the block is idle.
module round_robin_thread_scheduler_core #(
    parameter int MAX_THREADS = rrts_pkg::MAX_THREADS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // request channel
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [39:0]                       s_tdata,   // thread_slot[3:0], duration[35:4]
    input  logic [2:0]                        s_tuser,   // mode[2:0]
    // result channel
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [15:0]                       m_tdata,   // running_slot[3:0], previous_slot[7:4],
                                                         // switched[8], fell_back[9],
                                                         // reclaimed[10], rejected[11]
    // configuration writes
    input  logic                              cfg_wr_en,
    input  logic [rrts_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [rrts_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);

    logic [rrts_pkg::RATE_W-1:0] rate_reg;
    logic [rrts_pkg::SLOT_W-1:0] kslot_reg;
    logic                        out_valid_reg;
    rrts_pkg::result_t           out_data_reg;
    rrts_pkg::result_t           res;
    logic                        res_valid, res_ready, idle;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg  <= rrts_pkg::TICK_RATE_RST;
            kslot_reg <= rrts_pkg::KERNEL_SLOT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                rrts_pkg::REG_TICK_RATE:   rate_reg  <= cfg_wr_data;
                rrts_pkg::REG_KERNEL_SLOT: kslot_reg <= cfg_wr_data[rrts_pkg::SLOT_W-1:0];
                default: ;
            endcase
        end
    end

    rrts_ctrl #(
        .MAX_THREADS (MAX_THREADS)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (s_tvalid && s_tready),
        .mode        (s_tuser),
        .slot        (s_tdata[3:0]),
        .dur         (s_tdata[35:4]),
        .tick_rate   (rate_reg),
        .kernel_slot (kslot_reg),
        .idle        (idle),
        .res_valid   (res_valid),
        .res         (res),
        .res_ready   (res_ready)
    );

    assign s_tready  = idle;
    assign res_ready = !out_valid_reg || m_tready;

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_ready) begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            out_data_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_data_reg};

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while an event was in progress");

    a_reject_no_switch: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[11]) |-> (!m_tdata[8] && !m_tdata[10]))
        else $error("rejected request changed the running thread");

    a_reclaim_switch: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[10]) |-> m_tdata[8])
        else $error("reclaim without a thread switch");
`endif

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the round-robin thread scheduler core.
module testbench;
    import rrts_pkg::*;

    localparam int NSLOTS = MAX_THREADS_DEF;
    localparam int SETTLE = 130;
    localparam int LIMIT  = 600000;
    localparam logic [MODE_W-1:0] MODE_UNDEF = 3'd7;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [39:0]           s_tdata = '0;   // thread_slot[3:0], duration[35:4]
    logic [2:0]            s_tuser = '0;   // mode[2:0]
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [15:0]           m_tdata;        // running[3:0], previous[7:4], switched[8],
                                           // fell_back[9], reclaimed[10], rejected[11]
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    round_robin_thread_scheduler_core uut (.*);

    always #6 aclk = ~aclk;

    // Shadow scheduler state
    logic [RATE_W-1:0] rate_hz;
    logic [SLOT_W-1:0] kernel_slot;
    logic [SLOT_W-1:0] cur_slot;
    logic [1:0]        slot_st [NSLOTS];
    logic [SLOT_W-1:0] ready_q [$];
    logic [SLOT_W-1:0] sleep_q [$];
    logic [TICK_W-1:0] wake_at [NSLOTS];
    logic [TICK_W-1:0] tick_now;

    result_t           sched_results [$];
    int                mismatches = 0;
    int                cycles = 0;
    bit                idle_on = 1'b1;
    int                hold_cycles = 0;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic void drop_slot(ref logic [SLOT_W-1:0] q[$], input logic [SLOT_W-1:0] s);
        for (int k = 0; k < q.size(); k++) begin
            if (q[k] == s) begin
                q.delete(k);
                return;
            end
        end
    endfunction

    function automatic void enqueue(ref logic [SLOT_W-1:0] q[$], input logic [SLOT_W-1:0] s);
        if (q.size() < NSLOTS) q.push_back(s);
    endfunction

    // Pick the next thread: requeue, wake expired sleepers, take head or kernel slot
    function automatic void pick_next(input bit dying, inout result_t r);
        logic [SLOT_W-1:0] prev;
        logic [SLOT_W-1:0] nxt;
        logic [SLOT_W-1:0] s;
        int k;
        prev = cur_slot;
        k = 0;
        if (slot_st[prev] == ST_RUNNING) begin
            slot_st[prev] = ST_READY;
            enqueue(ready_q, prev);
        end
        while (k < sleep_q.size()) begin
            s = sleep_q[k];
            if (tick_now >= wake_at[s]) begin
                sleep_q.delete(k);
                slot_st[s] = ST_READY;
                enqueue(ready_q, s);
            end else begin
                k++;
            end
        end
        if (ready_q.size() > 0) begin
            nxt = ready_q.pop_front();
        end else begin
            nxt = kernel_slot;
            drop_slot(sleep_q, nxt);
            r.fell_back = 1'b1;
        end
        cur_slot = nxt;
        slot_st[nxt] = ST_RUNNING;
        r.running_slot = nxt;
        r.switched = (prev != nxt);
        r.reclaimed = dying && (prev != nxt);
    endfunction

    function automatic void retire_running(inout result_t r);
        drop_slot(sleep_q, cur_slot);
        drop_slot(ready_q, cur_slot);
        slot_st[cur_slot] = ST_FREE;
        pick_next(1'b1, r);
    endfunction

    function automatic result_t predict_event(input logic [MODE_W-1:0] mode,
                                              input logic [SLOT_W-1:0] slot,
                                              input logic [DUR_W-1:0] dur);
        result_t r;
        logic [TICK_W-1:0] delta;
        r = '0;
        r.running_slot = cur_slot;
        r.previous_slot = cur_slot;
        case (mode)
            MODE_SCHED: pick_next(1'b0, r);
            MODE_ADD: begin
                if (slot_st[slot] != ST_FREE) begin
                    r.rejected = 1'b1;
                end else begin
                    slot_st[slot] = ST_READY;
                    enqueue(ready_q, slot);
                end
            end
            MODE_SLEEP_MS, MODE_SLEEP_S: begin
                if (dur != 0) begin
                    delta = TICK_W'(dur) * TICK_W'(rate_hz);
                    if (mode == MODE_SLEEP_MS) delta = delta / MS_PER_S;
                    wake_at[cur_slot] = tick_now + delta;
                    slot_st[cur_slot] = ST_BLOCKED;
                    drop_slot(ready_q, cur_slot);
                    drop_slot(sleep_q, cur_slot);
                    enqueue(sleep_q, cur_slot);
                    pick_next(1'b0, r);
                end
            end
            MODE_KILL: begin
                if (slot_st[slot] == ST_FREE) begin
                    r.rejected = 1'b1;
                end else if (slot == cur_slot) begin
                    retire_running(r);
                end else begin
                    drop_slot(sleep_q, slot);
                    drop_slot(ready_q, slot);
                    slot_st[slot] = ST_FREE;
                end
            end
            MODE_EXIT: retire_running(r);
            MODE_TICK: tick_now = tick_now + 1;
            default: ;
        endcase
        return r;
    endfunction

    // Result checker: sample at the falling edge, handshake completes at the next rising edge
    initial begin
        result_t got;
        result_t want;
        forever begin
            @(negedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got = result_t'(m_tdata[11:0]);
                if (sched_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %h", m_tdata);
                end else begin
                    want = sched_results.pop_front();
                    if (got != want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: expected %h, got %h", want, got);
                    end
                end
            end
        end
    end

    // Result-side readiness: random stall bursts plus a requested long hold
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                hold_cycles--;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                if (idle_on && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 13);
            end
        end
    end

    // Offer one request, wait for it to be taken, then predict its result
    task automatic send_request(input logic [MODE_W-1:0] mode, input logic [SLOT_W-1:0] slot,
                                input logic [DUR_W-1:0] dur);
        bit rdy;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= {4'b0, dur, slot};
        do begin
            @(negedge aclk);
            rdy = s_tready;
            @(posedge aclk);
        end while (!rdy);
        sched_results.push_back(predict_event(mode, slot, dur));
    endtask

    task automatic go_quiet();
        s_tvalid <= 1'b0;
        while (sched_results.size() > 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        go_quiet();
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_TICK_RATE) rate_hz = val;
        else kernel_slot = val[SLOT_W-1:0];
    endtask

    // Weighted random event; short sleeps so sleepers actually wake
    task automatic send_random();
        int pick;
        int dsel;
        logic [MODE_W-1:0] mode;
        logic [DUR_W-1:0] dur;
        pick = $urandom_range(0, 99);
        dsel = $urandom_range(0, 19);
        if (pick < 25) mode = MODE_SCHED;
        else if (pick < 40) mode = MODE_ADD;
        else if (pick < 55) mode = MODE_SLEEP_MS;
        else if (pick < 60) mode = MODE_SLEEP_S;
        else if (pick < 70) mode = MODE_KILL;
        else if (pick < 77) mode = MODE_EXIT;
        else if (pick < 98) mode = MODE_TICK;
        else mode = MODE_UNDEF;
        if (dsel < 3) dur = '0;
        else if (dsel < 14) dur = $urandom_range(1, 4);
        else if (dsel < 18) dur = $urandom_range(5, 40);
        else dur = $urandom;
        send_request(mode, SLOT_W'($urandom_range(0, NSLOTS - 1)), dur);
    endtask

    task automatic test_directed();
        send_request(MODE_TICK, 4'd0, 32'd0);
        send_request(MODE_UNDEF, 4'd9, 32'hFFFF_FFFF);  // undefined event
        send_request(MODE_ADD, 4'd15, 32'd0);
        send_request(MODE_ADD, 4'd15, 32'd0);           // slot already used
        send_request(MODE_KILL, 4'd3, 32'd0);           // slot free
        send_request(MODE_SCHED, 4'd0, 32'd0);
        send_request(MODE_SLEEP_MS, 4'd0, 32'd0);       // zero sleep does nothing
        send_request(MODE_ADD, 4'd1, 32'd0);
        send_request(MODE_ADD, 4'd2, 32'd0);
        send_request(MODE_SLEEP_MS, 4'd0, 32'd2);
        send_request(MODE_SLEEP_S, 4'd0, 32'hFFFF_FFFF);
        send_request(MODE_TICK, 4'd0, 32'd0);
        send_request(MODE_TICK, 4'd0, 32'd0);
        send_request(MODE_SCHED, 4'd0, 32'd0);
        send_request(MODE_KILL, 4'd1, 32'd0);           // kill of a waiting thread
        send_request(MODE_KILL, cur_slot, 32'd0);       // kill of the running thread
        send_request(MODE_EXIT, 4'd0, 32'd0);
        send_request(MODE_EXIT, 4'd0, 32'd0);           // kernel exits with nothing ready
        send_request(MODE_SCHED, 4'd0, 32'd0);
        send_request(MODE_ADD, 4'd0, 32'd0);
        send_request(MODE_KILL, 4'd15, 32'd0);
        send_request(MODE_SCHED, 4'd10, 32'h5555_AAAA);
    endtask

    task automatic test_random_phase(input int n);
        repeat (n) send_random();
    endtask

    // Hold the result side off long enough that the block stalls its input
    task automatic test_backpressure();
        hold_cycles = 400;
        repeat (12) send_random();
    endtask

    task automatic test_settings();
        write_reg(REG_KERNEL_SLOT, 17'd15);
        write_reg(REG_TICK_RATE, 17'd1);
        test_random_phase(110);
        write_reg(REG_TICK_RATE, 17'd0);                // new sleepers wake at next schedule
        write_reg(REG_KERNEL_SLOT, 17'd5);
        test_random_phase(90);
        write_reg(REG_TICK_RATE, 17'h1FFFF);
        write_reg(REG_KERNEL_SLOT, CFG_DATA_W'($urandom_range(0, NSLOTS - 1)));
        test_random_phase(90);
        write_reg(REG_TICK_RATE, 17'd100000);
        write_reg(REG_KERNEL_SLOT, 17'd0);
        test_random_phase(90);
        write_reg(REG_TICK_RATE, 17'd1000);
        test_backpressure();
    endtask

    task automatic test_full_rate();
        idle_on = 1'b0;
        test_random_phase(80);
    endtask

    initial begin
        rate_hz = TICK_RATE_RST;
        kernel_slot = KERNEL_SLOT_RST;
        cur_slot = '0;
        tick_now = '0;
        for (int k = 0; k < NSLOTS; k++) begin
            slot_st[k] = ST_FREE;
            wake_at[k] = '0;
        end
        slot_st[0] = ST_RUNNING;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random_phase(60);
        test_settings();
        test_full_rate();
        go_quiet();
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/rrts_pkg.sv
rtl/rrts_conv.sv
rtl/rrts_ctrl.sv
rtl/round_robin_thread_scheduler_core.sv
tb/testbench.sv
